[rtl/ffck_pkg.sv]
// ----------------------------------------------------------------------------
// ffck_pkg
// Shared types, codes and constants for the four-function calculator keypad.
// ----------------------------------------------------------------------------
package ffck_pkg;

  localparam int FRAC_DIGITS = 8;
  localparam int VALUE_W     = 64;
  localparam int DISP_W      = 61;

  localparam logic [VALUE_W-1:0] LIMIT      = 64'd999999999999999999;
  localparam logic [VALUE_W-1:0] LIMIT_DIV10 = LIMIT / 10;
  localparam logic [VALUE_W-1:0] SCALE      = 64'd100000000;
  localparam logic [VALUE_W-1:0] SCALE_X10  = 64'd1000000000;
  localparam logic signed [VALUE_W:0] LIM_POS = 65'sd999999999999999999;
  localparam logic signed [VALUE_W:0] LIM_NEG = -65'sd999999999999999999;

  typedef enum logic [2:0] {
    ACT_DIGIT = 3'd0,
    ACT_OPER  = 3'd1,
    ACT_EQUAL = 3'd2,
    ACT_POINT = 3'd3,
    ACT_CLEAR = 3'd4,
    ACT_BKSP  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } pend_op_t;

  typedef enum logic [0:0] {
    MODE_MUL = 1'b0,
    MODE_DIV = 1'b1
  } unit_mode_t;

  typedef struct packed {
    logic       start;
    unit_mode_t mode;
  } unit_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_ADDCHK,
    S_MUL,
    S_DIV,
    S_BSDIV,
    S_BSMUL,
    S_BSFIN,
    S_EMIT
  } state_t;

  function automatic logic [VALUE_W-1:0] pow10(input logic [4:0] n);
    logic [VALUE_W-1:0] p;
    case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

[rtl/ffck_muldiv.sv]
// ----------------------------------------------------------------------------
// ffck_muldiv
// Iterative shift-add multiplier and restoring divider on one 65-bit adder.
// ----------------------------------------------------------------------------
module ffck_muldiv (
  input  logic                         clk,
  input  logic                         rst,
  input  ffck_pkg::unit_ctrl_t         ctrl,
  input  logic [ffck_pkg::VALUE_W-1:0] ld_hi,
  input  logic [ffck_pkg::VALUE_W-1:0] ld_lo,
  input  logic [ffck_pkg::VALUE_W-1:0] opnd_in,
  output logic                         done,
  output logic [ffck_pkg::VALUE_W-1:0] hi,
  output logic [ffck_pkg::VALUE_W-1:0] lo,
  output logic [ffck_pkg::VALUE_W-1:0] rem
);

  logic                         busy;
  logic [6:0]                   cnt;
  ffck_pkg::unit_mode_t         mode;
  logic [ffck_pkg::VALUE_W-1:0] opnd;
  logic [ffck_pkg::VALUE_W:0]   x;
  logic [ffck_pkg::VALUE_W:0]   y;
  logic [ffck_pkg::VALUE_W:0]   sum;
  logic                         sub;
  logic                         ge;
  logic                         last;

  always_comb begin
    sub  = (mode == ffck_pkg::MODE_DIV);
    x    = sub ? {rem, hi[ffck_pkg::VALUE_W-1]} : {1'b0, hi};
    y    = (sub || lo[0]) ? {1'b0, opnd} : '0;
    sum  = x + (sub ? ~y : y) + {{ffck_pkg::VALUE_W{1'b0}}, sub};
    ge   = !sum[ffck_pkg::VALUE_W];
    last = sub ? (cnt == 7'd127) : (cnt == 7'd63);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        mode <= ctrl.mode;
        hi   <= ld_hi;
        lo   <= ld_lo;
        opnd <= opnd_in;
        rem  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (sub) begin
          rem <= ge ? sum[ffck_pkg::VALUE_W-1:0] : x[ffck_pkg::VALUE_W-1:0];
          hi  <= {hi[ffck_pkg::VALUE_W-2:0], lo[ffck_pkg::VALUE_W-1]};
          lo  <= {lo[ffck_pkg::VALUE_W-2:0], ge};
        end else begin
          {hi, lo} <= {sum, lo[ffck_pkg::VALUE_W-1:1]};
        end
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/four_function_calculator_keys_top.sv]
// ----------------------------------------------------------------------------
// four_function_calculator_keys_top
// Keypress-driven four-function calculator, decimal fixed point scaled 10^8.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, action, digit,        | key in
//          | operator_code                             |
//  out     | out_valid, out_ready, display_value,      | display out
//          | error, point_shown, fraction_digits       |
//
// One transaction at a time: in_ready is high only while the sequencer idles.
// Multiply and a divide by a nonzero entry run 64 multiply steps and then 128
// divide steps through the single 65-bit adder of ffck_muldiv; a backspace on a
// digit runs the divide steps and, without a point, the multiply steps after them.
// Reset (rst, synchronous) returns the calculator to a cleared display.
// A stalled output holds the sequencer in its emit state until taken.
//
module four_function_calculator_keys_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          action,
  input  logic [3:0]                          digit,
  input  logic [1:0]                          operator_code,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ffck_pkg::DISP_W-1:0]  display_value,
  output logic                                error,
  output logic                                point_shown,
  output logic [3:0]                          fraction_digits
);

  localparam int W = ffck_pkg::VALUE_W;

  // calculator state
  ffck_pkg::state_t       state, state_next;
  logic signed [W-1:0]    entry, entry_next;
  logic signed [W-1:0]    acc, acc_next;
  ffck_pkg::pend_op_t     pending, pending_next;
  logic                   awaiting, awaiting_next;
  logic                   point, point_next;
  logic [3:0]             fc, fc_next;
  logic                   err, err_next;

  // latched key and scratch
  ffck_pkg::action_t      key, key_next;
  logic [3:0]             dig, dig_next;
  logic [1:0]             opc, opc_next;
  logic signed [W:0]      tmp, tmp_next;
  logic                   ok1, ok1_next;
  logic                   neg, neg_next;

  // unit interface
  ffck_pkg::unit_ctrl_t   uctrl;
  logic [W-1:0]           u_ld_hi, u_ld_lo, u_opnd;
  logic                   u_done;
  logic [W-1:0]           u_hi, u_lo, u_rem;

  // effective entry after a digit or point opens a new operand
  logic signed [W-1:0]    e_eff;
  logic                   pt_eff;
  logic [3:0]             fc_eff;
  logic [W-1:0]           mag_e, mag_a, mag_b, mag_acc_in;
  logic [W-1:0]           add_int;
  logic signed [W:0]      s_int;
  logic [W-1:0]           m_bs;
  logic                   post;
  logic                   start_apply;
  logic                   accept;

  ffck_muldiv u_md (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (uctrl),
    .ld_hi   (u_ld_hi),
    .ld_lo   (u_ld_lo),
    .opnd_in (u_opnd),
    .done    (u_done),
    .hi      (u_hi),
    .lo      (u_lo),
    .rem     (u_rem)
  );

  assign in_ready = (state == ffck_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    e_eff   = awaiting ? '0 : entry;
    pt_eff  = awaiting ? 1'b0 : point;
    fc_eff  = awaiting ? 4'd0 : fc;
    mag_e   = e_eff[W-1] ? W'(-e_eff) : W'(e_eff);
    mag_a   = acc[W-1] ? W'(-acc) : W'(acc);
    mag_b   = entry[W-1] ? W'(-entry) : W'(entry);
    mag_acc_in = entry[W-1] ? W'(-entry) : W'(entry);
    add_int = W'({60'd0, dig}) * ffck_pkg::SCALE;
    s_int   = tmp + $signed({1'b0, add_int});
    m_bs    = mag_acc_in - u_rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffck_pkg::S_IDLE;
      entry    <= '0;
      acc      <= '0;
      pending  <= ffck_pkg::OP_NONE;
      awaiting <= 1'b1;
      point    <= 1'b0;
      fc       <= '0;
      err      <= 1'b0;
    end else begin
      state    <= state_next;
      entry    <= entry_next;
      acc      <= acc_next;
      pending  <= pending_next;
      awaiting <= awaiting_next;
      point    <= point_next;
      fc       <= fc_next;
      err      <= err_next;
    end
  end

  // scratch holds payload only
  always_ff @(posedge clk) begin
    key <= key_next;
    dig <= dig_next;
    opc <= opc_next;
    tmp <= tmp_next;
    ok1 <= ok1_next;
    neg <= neg_next;
  end

  always_comb begin
    state_next    = state;
    entry_next    = entry;
    acc_next      = acc;
    pending_next  = pending;
    awaiting_next = awaiting;
    point_next    = point;
    fc_next       = fc;
    err_next      = err;
    key_next      = key;
    dig_next      = dig;
    opc_next      = opc;
    tmp_next      = tmp;
    ok1_next      = ok1;
    neg_next      = neg;
    uctrl         = '{start: 1'b0, mode: ffck_pkg::MODE_MUL};
    u_ld_hi       = '0;
    u_ld_lo       = '0;
    u_opnd        = '0;
    post          = 1'b0;
    start_apply   = 1'b0;

    unique case (state)
      ffck_pkg::S_IDLE: begin
        if (accept) begin
          key_next   = ffck_pkg::action_t'(action);
          dig_next   = digit;
          opc_next   = operator_code;
          state_next = ffck_pkg::S_EMIT;
          if (action == ffck_pkg::ACT_CLEAR) begin
            entry_next    = '0;
            acc_next      = '0;
            pending_next  = ffck_pkg::OP_NONE;
            awaiting_next = 1'b1;
            point_next    = 1'b0;
            fc_next       = '0;
            err_next      = 1'b0;
          end else if (!err) begin
            case (action) inside
              ffck_pkg::ACT_DIGIT: begin
                if (digit <= 4'd9) begin
                  if (awaiting) begin
                    entry_next    = '0;
                    point_next    = 1'b0;
                    fc_next       = '0;
                    awaiting_next = 1'b0;
                  end
                  if (pt_eff) begin
                    if (fc_eff < 4'd8) begin
                      tmp_next = {e_eff[W-1], e_eff} + $signed({1'b0,
                        W'({60'd0, digit}) * ffck_pkg::pow10(5'(4'd7 - fc_eff))});
                      state_next = ffck_pkg::S_CHK;
                    end
                  end else begin
                    ok1_next   = (mag_e <= ffck_pkg::LIMIT_DIV10);
                    tmp_next   = $signed({1'b0, (mag_e << 3) + (mag_e << 1)});
                    neg_next   = e_eff[W-1];
                    state_next = ffck_pkg::S_CHK;
                  end
                end
              end
              ffck_pkg::ACT_OPER, ffck_pkg::ACT_EQUAL: begin
                if (action == ffck_pkg::ACT_EQUAL && pending == ffck_pkg::OP_NONE) begin
                  state_next = ffck_pkg::S_EMIT;
                end else if (!awaiting && pending != ffck_pkg::OP_NONE) begin
                  start_apply = 1'b1;
                end else begin
                  if (!awaiting) acc_next = entry;
                  post = 1'b1;
                end
              end
              ffck_pkg::ACT_POINT: begin
                if (awaiting) begin
                  entry_next    = '0;
                  awaiting_next = 1'b0;
                end
                if (!pt_eff) fc_next = '0;
                point_next = 1'b1;
              end
              ffck_pkg::ACT_BKSP: begin
                if (!awaiting) begin
                  neg_next = entry[W-1];
                  if (point) begin
                    if (fc != 4'd0) begin
                      uctrl      = '{start: 1'b1, mode: ffck_pkg::MODE_DIV};
                      u_ld_lo    = mag_b;
                      u_opnd     = ffck_pkg::pow10(5'(4'd9 - fc));
                      state_next = ffck_pkg::S_BSDIV;
                    end else begin
                      point_next = 1'b0;
                      if (entry == '0) awaiting_next = 1'b1;
                    end
                  end else begin
                    uctrl      = '{start: 1'b1, mode: ffck_pkg::MODE_DIV};
                    u_ld_lo    = mag_b;
                    u_opnd     = ffck_pkg::SCALE_X10;
                    state_next = ffck_pkg::S_BSDIV;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end

      ffck_pkg::S_CHK: begin
        state_next = ffck_pkg::S_EMIT;
        if (point) begin
          if (tmp <= ffck_pkg::LIM_POS && tmp >= ffck_pkg::LIM_NEG) begin
            entry_next = tmp[W-1:0];
            fc_next    = fc + 4'd1;
          end
        end else if (ok1 && s_int <= ffck_pkg::LIM_POS) begin
          entry_next = neg ? W'($signed({1'b0, add_int}) - tmp) : s_int[W-1:0];
        end
      end

      ffck_pkg::S_ADDCHK: begin
        if (tmp > ffck_pkg::LIM_POS || tmp < ffck_pkg::LIM_NEG) begin
          err_next = 1'b1;
        end else begin
          acc_next   = tmp[W-1:0];
          entry_next = tmp[W-1:0];
        end
        post = 1'b1;
      end

      ffck_pkg::S_MUL: begin
        if (u_done) begin
          uctrl      = '{start: 1'b1, mode: ffck_pkg::MODE_DIV};
          u_ld_hi    = u_hi;
          u_ld_lo    = u_lo;
          u_opnd     = (pending == ffck_pkg::OP_MUL) ? ffck_pkg::SCALE : mag_b;
          state_next = ffck_pkg::S_DIV;
        end
      end

      ffck_pkg::S_DIV: begin
        if (u_done) begin
          if (u_hi != '0 || u_lo > ffck_pkg::LIMIT) begin
            err_next = 1'b1;
          end else begin
            acc_next   = neg ? -$signed(u_lo) : $signed(u_lo);
            entry_next = neg ? -$signed(u_lo) : $signed(u_lo);
          end
          post = 1'b1;
        end
      end

      ffck_pkg::S_BSDIV: begin
        if (u_done) begin
          if (point) begin
            tmp_next   = $signed({1'b0, m_bs});
            fc_next    = fc - 4'd1;
            state_next = ffck_pkg::S_BSFIN;
          end else begin
            uctrl      = '{start: 1'b1, mode: ffck_pkg::MODE_MUL};
            u_ld_lo    = u_lo;
            u_opnd     = ffck_pkg::SCALE;
            state_next = ffck_pkg::S_BSMUL;
          end
        end
      end

      ffck_pkg::S_BSMUL: begin
        if (u_done) begin
          tmp_next   = $signed({1'b0, u_lo});
          state_next = ffck_pkg::S_BSFIN;
        end
      end

      ffck_pkg::S_BSFIN: begin
        entry_next = neg ? W'(-tmp) : tmp[W-1:0];
        if (tmp == '0 && !point) awaiting_next = 1'b1;
        state_next = ffck_pkg::S_EMIT;
      end

      ffck_pkg::S_EMIT: begin
        if (!out_valid || out_ready) state_next = ffck_pkg::S_IDLE;
      end

      default: state_next = ffck_pkg::S_IDLE;
    endcase

    // launch the pending operation on acc and entry
    if (start_apply) begin
      neg_next = acc[W-1] ^ entry[W-1];
      case (pending)
        ffck_pkg::OP_ADD: begin
          tmp_next   = {acc[W-1], acc} + {entry[W-1], entry};
          state_next = ffck_pkg::S_ADDCHK;
        end
        ffck_pkg::OP_SUB: begin
          tmp_next   = {acc[W-1], acc} - {entry[W-1], entry};
          state_next = ffck_pkg::S_ADDCHK;
        end
        ffck_pkg::OP_MUL: begin
          uctrl      = '{start: 1'b1, mode: ffck_pkg::MODE_MUL};
          u_ld_lo    = mag_a;
          u_opnd     = mag_b;
          state_next = ffck_pkg::S_MUL;
        end
        default: begin
          if (entry == '0) begin
            err_next = 1'b1;
            post     = 1'b1;
          end else begin
            uctrl      = '{start: 1'b1, mode: ffck_pkg::MODE_MUL};
            u_ld_lo    = mag_a;
            u_opnd     = ffck_pkg::SCALE;
            state_next = ffck_pkg::S_MUL;
          end
        end
      endcase
    end

    // close an operator or equals key
    if (post) begin
      pending_next  = (key_next == ffck_pkg::ACT_OPER) ?
                      ffck_pkg::pend_op_t'({1'b0, opc_next} + 3'd1) : ffck_pkg::OP_NONE;
      awaiting_next = 1'b1;
      point_next    = 1'b0;
      fc_next       = '0;
      state_next    = ffck_pkg::S_EMIT;
    end
  end

  // output register: load the display when the emit state may hand it over
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ffck_pkg::S_EMIT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ffck_pkg::S_EMIT && (!out_valid || out_ready)) begin
      display_value   <= err ? '0 :
                         (awaiting ? acc[ffck_pkg::DISP_W-1:0] : entry[ffck_pkg::DISP_W-1:0]);
      error           <= err;
      point_shown     <= !err && point;
      fraction_digits <= (!err && point) ? fc : 4'd0;
    end
  end

endmodule

[rtl/ffck_chk.sv]
// ----------------------------------------------------------------------------
// ffck_chk
// Port-level checks for the calculator keypad, bound to the top level.
// ----------------------------------------------------------------------------
module ffck_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [ffck_pkg::DISP_W-1:0] display_value,
  input logic                               error,
  input logic                               point_shown,
  input logic [3:0]                         fraction_digits
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("key accepted while another is in flight");

  a_error_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> display_value == '0 && !point_shown && fraction_digits == 4'd0)
    else $error("error display not blanked");

  a_frac_needs_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_shown |-> fraction_digits == 4'd0)
    else $error("fraction digits without point");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fraction_digits <= 4'd8)
    else $error("too many fraction digits");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(display_value))
    else $error("stalled result changed");

endmodule

bind four_function_calculator_keys_top ffck_chk u_ffck_chk (.*);
